>>> src/uule_pkg.sv
package uule_pkg;

   // Number of raw bytes gathered into one encoded line.
   localparam int LINE_BYTES = 45;

   // Width of a byte index or count within one line (holds LINE_BYTES itself).
   localparam int IDX_W = $clog2(LINE_BYTES + 1);

   // Characters used by the encoder.
   localparam logic [7:0] CHAR_ZERO   = 8'h60;
   localparam logic [7:0] CHAR_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_THREE  = 8'h33;
   localparam logic [7:0] CHAR_D      = 8'h44;
   localparam logic [7:0] CHAR_X      = 8'h58;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   // Register addresses.
   localparam logic [1:0] CSR_ADDR_ESCAPE_EQUALS = 2'd0;

   // One output unit: up to six characters and their count.
   typedef struct packed {
      logic [5:0][7:0] chars;
      logic [2:0]      count;
      logic            line_end;
   } unit_type;

   // Zero maps to a backquote, any other value to its low six bits plus 0x20.
   function automatic logic [7:0] map_char(input logic [7:0] v);
      logic [7:0] res;
      if (v == 8'd0) begin
         res = CHAR_ZERO;
      end else begin
         res = {2'b00, v[5:0]} + CHAR_OFFSET;
      end
      return res;
   endfunction

   // Builds a unit from one character, with optional escaping and line end.
   function automatic unit_type build_unit(input logic [7:0] ch,
                                           input logic       endline,
                                           input logic       esc);
      unit_type u;
      u = '0;
      if (esc && (ch == CHAR_EQUALS)) begin
         u.chars[0] = CHAR_EQUALS;
         u.chars[1] = CHAR_THREE;
         u.chars[2] = CHAR_D;
         u.count    = 3'd3;
         if (endline) begin
            u.chars[3] = CHAR_X;
            u.chars[4] = CHAR_CR;
            u.chars[5] = CHAR_LF;
            u.count    = 3'd6;
         end
      end else begin
         u.chars[0] = ch;
         u.count    = 3'd1;
         if (endline) begin
            u.chars[1] = CHAR_X;
            u.chars[2] = CHAR_CR;
            u.chars[3] = CHAR_LF;
            u.count    = 3'd4;
         end
      end
      u.line_end = endline;
      return u;
   endfunction

endpackage

>>> src/uuencode_line_encoder_unit.sv
// A data byte that does not complete a line is stored in the line memory, with no output.
// A completing byte or a finish moves the sequencer to ST_LEN, which sends the line's length
// character; each group of three bytes is then read through the single read port of the line
// memory in ST_RD0, ST_RD1 and ST_RD2 and sent as four output characters in ST_GRP.
// Reset (synchronous, active high) empties the line, clears escaping and clears rsp_valid.
module uuencode_line_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte_0,
   output logic [7:0]  rsp_out_byte_1,
   output logic [7:0]  rsp_out_byte_2,
   output logic [7:0]  rsp_out_byte_3,
   output logic [7:0]  rsp_out_byte_4,
   output logic [7:0]  rsp_out_byte_5,
   output logic [2:0]  rsp_out_count,
   output logic        rsp_line_end,
   output logic        rsp_run_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = uule_pkg::IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_GRP,
      ST_CHK
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    pending_ff, pending_in;
   logic [IDX_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [1:0]          char_ff, char_in;
   logic [5:0]          sum_ff, sum_in;
   logic [7:0]          a_ff, a_in;
   logic [7:0]          b_ff, b_in;
   logic                empty_ff, empty_in;
   logic                esc_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   uule_pkg::unit_type  unit_ff, unit_in;
   logic                last_ff, last_in;

   // Line memory.
   logic [7:0]          line_mem [uule_pkg::LINE_BYTES];
   logic [7:0]          rdata_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                rd_en;
   logic                wr_en;

   logic                req_fire;
   logic                out_free;
   logic [IDX_W:0]      pending_inc;
   logic [7:0]          c_byte;
   logic [7:0]          grp_char;
   logic                b_present;
   logic                c_present;
   logic                grp_more;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pending_inc = {1'b0, pending_ff} + {{IDX_W{1'b0}}, 1'b1};
   assign wr_en       = req_fire && !req_command
                        && ({1'b0, pending_ff} < (IDX_W+1)'(uule_pkg::LINE_BYTES));

   // Bytes beyond the line's count read as zero within the last group.
   assign b_present = (({1'b0, idx_ff} + (IDX_W+1)'(1)) < {1'b0, n_ff});
   assign c_present = (({1'b0, idx_ff} + (IDX_W+1)'(2)) < {1'b0, n_ff});
   assign grp_more  = (({1'b0, idx_ff} + (IDX_W+1)'(3)) < {1'b0, n_ff});
   assign c_byte    = c_present ? rdata_ff : 8'd0;

   // Character of the current group selected by the character counter.
   always_comb begin
      case (char_ff)
         2'd0:    grp_char = uule_pkg::map_char({2'b00, a_ff[7:2]});
         2'd1:    grp_char = uule_pkg::map_char({2'b00, a_ff[1:0], b_ff[7:4]});
         2'd2:    grp_char = uule_pkg::map_char({2'b00, b_ff[3:0], c_byte[7:6]});
         default: grp_char = uule_pkg::map_char(c_byte);
      endcase
   end

   // Memory read address for the three bytes of a group.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      case (state_ff)
         ST_RD0: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         ST_RD1: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_ff + IDX_W'(1));
         end
         ST_RD2: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_ff + IDX_W'(2));
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[pending_ff] <= req_data_byte;
      end
      if (rd_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
   end

   // Sequencer next state and output unit.
   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      sum_in       = sum_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      empty_in     = empty_ff;
      unit_in      = unit_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_command) begin
                  pending_in = pending_inc[IDX_W-1:0];
                  if (pending_inc == (IDX_W+1)'(uule_pkg::LINE_BYTES)) begin
                     pending_in = '0;
                     n_in       = IDX_W'(uule_pkg::LINE_BYTES);
                     empty_in   = 1'b0;
                     state_in   = ST_LEN;
                  end
               end else begin
                  pending_in = '0;
                  if (pending_ff != '0) begin
                     n_in     = pending_ff;
                     empty_in = 1'b1;
                  end else begin
                     n_in     = '0;
                     empty_in = 1'b0;
                  end
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (out_free) begin
               unit_in      = uule_pkg::build_unit(uule_pkg::map_char({2'b00, n_ff}),
                                                   1'b0, esc_ff);
               last_in      = 1'b0;
               rsp_valid_in = 1'b1;
               idx_in       = '0;
               sum_in       = '0;
               state_in     = (n_ff != '0) ? ST_RD0 : ST_CHK;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            a_in     = rdata_ff;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            b_in     = b_present ? rdata_ff : 8'd0;
            char_in  = 2'd0;
            state_in = ST_GRP;
         end
         ST_GRP: begin
            if (out_free) begin
               unit_in      = uule_pkg::build_unit(grp_char, 1'b0, esc_ff);
               last_in      = 1'b0;
               rsp_valid_in = 1'b1;
               char_in      = char_ff + 2'd1;
               if (char_ff == 2'd3) begin
                  sum_in   = 6'(sum_ff + a_ff[5:0] + b_ff[5:0] + c_byte[5:0]);
                  idx_in   = IDX_W'(idx_ff + IDX_W'(3));
                  state_in = grp_more ? ST_RD0 : ST_CHK;
               end
            end
         end
         ST_CHK: begin
            if (out_free) begin
               unit_in      = uule_pkg::build_unit(uule_pkg::map_char({2'b00, sum_ff}),
                                                   1'b1, esc_ff);
               last_in      = !empty_ff;
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  empty_in = 1'b0;
                  n_in     = '0;
                  state_in = ST_LEN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         char_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         char_ff      <= char_in;
      end
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      unit_ff <= unit_in;
      last_ff <= last_in;
   end

   // Configuration register; the single register takes any write transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         esc_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == uule_pkg::CSR_ADDR_ESCAPE_EQUALS) begin
         csr_prdata = {31'd0, esc_ff};
      end
   end

   assign csr_pready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte_0 = unit_ff.chars[0];
   assign rsp_out_byte_1 = unit_ff.chars[1];
   assign rsp_out_byte_2 = unit_ff.chars[2];
   assign rsp_out_byte_3 = unit_ff.chars[3];
   assign rsp_out_byte_4 = unit_ff.chars[4];
   assign rsp_out_byte_5 = unit_ff.chars[5];
   assign rsp_out_count  = unit_ff.count;
   assign rsp_line_end   = unit_ff.line_end;
   assign rsp_run_last   = last_ff;

endmodule
